// ===== rtl/core/i2c_register_access_master_macros.svh =====
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define I2CRAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define I2CRAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/i2cram_pkg.sv =====
package i2cram_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int HALF_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [6:0]  DEV_ADDR_RST    = 7'd93;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd50;
  localparam logic [15:0] ACK_LIMIT_RST   = 16'd2000;

  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT   = 2'd2;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_REG_NACK  = 2'd2;
  localparam logic [1:0] ST_DATA_NACK = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START1, PH_WR_ADDRW, PH_ACK_ADDRW, PH_WR_REGHI, PH_ACK_REGHI,
    PH_WR_REGLO, PH_ACK_REGLO, PH_MID_STOP, PH_START2, PH_WR_ADDRR, PH_ACK_ADDRR,
    PH_RD_DATA, PH_RD_ACK, PH_WR_DATA, PH_ACK_DATA, PH_STOP_FINAL
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] reg_index;
    logic [7:0]  byte_count;
    logic [7:0]  wr_byte;
    logic        sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       busy_res;
    logic       byte_taken;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done_res;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [15:0] half_period;
    logic [15:0] ack_limit;
  } cfg_t;

endpackage

// ===== rtl/core/i2cram_engine.sv =====
module i2cram_engine #(
  parameter int TIMER_BITS = i2cram_pkg::TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  i2cram_pkg::in_word_t in_word,
  input  i2cram_pkg::cfg_t     cfg,
  output i2cram_pkg::out_word_t res
);

  localparam int CW = (TIMER_BITS > i2cram_pkg::HALF_W) ? TIMER_BITS : i2cram_pkg::HALF_W;
  localparam logic [CW:0] TMASK = (CW+1)'((64'd1 << TIMER_BITS) - 64'd1);

  function automatic logic is_start(i2cram_pkg::phase_t p);
    return p == i2cram_pkg::PH_START1 || p == i2cram_pkg::PH_START2;
  endfunction

  function automatic logic is_stop(i2cram_pkg::phase_t p);
    return p == i2cram_pkg::PH_MID_STOP || p == i2cram_pkg::PH_STOP_FINAL;
  endfunction

  function automatic logic is_write(i2cram_pkg::phase_t p);
    return p == i2cram_pkg::PH_WR_ADDRW || p == i2cram_pkg::PH_WR_REGHI ||
           p == i2cram_pkg::PH_WR_REGLO || p == i2cram_pkg::PH_WR_ADDRR ||
           p == i2cram_pkg::PH_WR_DATA;
  endfunction

  function automatic logic is_ack(i2cram_pkg::phase_t p);
    return p == i2cram_pkg::PH_ACK_ADDRW || p == i2cram_pkg::PH_ACK_REGHI ||
           p == i2cram_pkg::PH_ACK_REGLO || p == i2cram_pkg::PH_ACK_ADDRR ||
           p == i2cram_pkg::PH_ACK_DATA;
  endfunction

  function automatic logic [1:0] fail_code(i2cram_pkg::phase_t p);
    logic [1:0] c;
    c = i2cram_pkg::ST_DATA_NACK;
    if (p == i2cram_pkg::PH_ACK_ADDRW) c = i2cram_pkg::ST_ADDR_NACK;
    else if (p == i2cram_pkg::PH_ACK_REGHI || p == i2cram_pkg::PH_ACK_REGLO)
      c = i2cram_pkg::ST_REG_NACK;
    return c;
  endfunction

  i2cram_pkg::phase_t    phase_r, phase_nxt;
  logic [1:0]            sub_r, sub_nxt;
  logic [3:0]            bit_r, bit_nxt;
  logic                  rd_op_r, rd_op_nxt;
  logic [15:0]           reg_r, reg_nxt;
  logic [7:0]            left_r, left_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [TIMER_BITS-1:0] ack_cnt_r, ack_cnt_nxt;
  logic [1:0]            status_r, status_nxt;

  logic [CW:0]           half_ext, half_sat, lim_ext, lim_sat, timer_inc, cnt_cmp;
  logic [TIMER_BITS-1:0] cnt_wrap;

  i2cram_pkg::phase_t    pd_phase;
  logic [7:0]            pd_shift;
  logic                  pd_taken, pd_done, pd_dec;
  logic                  apply_pd;
  logic [6:0]            addr;

  logic scl, sda, oe, taken, rv, done;
  logic [7:0] rb;

  assign half_ext  = (CW+1)'(cfg.half_period);
  assign half_sat  = (half_ext == '0) ? (CW+1)'(1) : ((half_ext > TMASK) ? TMASK : half_ext);
  assign lim_ext   = (CW+1)'(cfg.ack_limit);
  assign lim_sat   = (lim_ext > TMASK) ? TMASK : lim_ext;
  assign timer_inc = (CW+1)'(timer_r) + (CW+1)'(1);
  assign cnt_wrap  = ack_cnt_r + TIMER_BITS'(1);
  assign cnt_cmp   = (CW+1)'(cnt_wrap);
  assign addr      = cfg.dev_addr;

  // Bus levels for the current step.
  always_comb begin
    scl = 1'b1;
    sda = 1'b1;
    oe  = 1'b0;
    if (is_start(phase_r)) begin
      scl = sub_r != 2'd0;
      sda = sub_r != 2'd2;
      oe  = sub_r != 2'd0;
    end else if (is_stop(phase_r)) begin
      scl = sub_r != 2'd0;
      sda = sub_r == 2'd2;
      oe  = 1'b1;
    end else if (is_write(phase_r)) begin
      oe = 1'b1;
      if (bit_r == 4'd0) begin
        scl = 1'b0;
        sda = 1'b0;
      end else if (sub_r == 2'd0) begin
        scl = 1'b0;
        sda = (bit_r == 4'd1) ? 1'b0 : shift_r[0];
      end else begin
        scl = sub_r == 2'd2;
        sda = shift_r[7];
      end
    end else if (is_ack(phase_r)) begin
      scl = sub_r == 2'd2;
    end else if (phase_r == i2cram_pkg::PH_RD_DATA) begin
      scl = bit_r != 4'd0 && sub_r == 2'd1;
    end else if (phase_r == i2cram_pkg::PH_RD_ACK) begin
      scl = sub_r == 2'd2;
      sda = (sub_r == 2'd0) ? 1'b1 : (left_r == 8'd0);
      oe  = sub_r != 2'd0;
    end
  end

  // Successor when the current phase completes.
  always_comb begin
    pd_phase = i2cram_pkg::PH_IDLE;
    pd_shift = 8'd0;
    pd_taken = 1'b0;
    pd_done  = 1'b0;
    pd_dec   = 1'b0;
    if (is_ack(phase_r) && status_r != i2cram_pkg::ST_OK) begin
      pd_phase = i2cram_pkg::PH_STOP_FINAL;
    end else begin
      unique case (phase_r)
        i2cram_pkg::PH_START1: begin
          pd_phase = i2cram_pkg::PH_WR_ADDRW;
          pd_shift = {addr, 1'b0};
        end
        i2cram_pkg::PH_WR_ADDRW:  pd_phase = i2cram_pkg::PH_ACK_ADDRW;
        i2cram_pkg::PH_ACK_ADDRW: begin
          pd_phase = i2cram_pkg::PH_WR_REGHI;
          pd_shift = reg_r[15:8];
        end
        i2cram_pkg::PH_WR_REGHI:  pd_phase = i2cram_pkg::PH_ACK_REGHI;
        i2cram_pkg::PH_ACK_REGHI: begin
          pd_phase = i2cram_pkg::PH_WR_REGLO;
          pd_shift = reg_r[7:0];
        end
        i2cram_pkg::PH_WR_REGLO:  pd_phase = i2cram_pkg::PH_ACK_REGLO;
        i2cram_pkg::PH_ACK_REGLO, i2cram_pkg::PH_ACK_DATA: begin
          if (phase_r == i2cram_pkg::PH_ACK_REGLO && rd_op_r) begin
            pd_phase = i2cram_pkg::PH_MID_STOP;
          end else if (left_r == 8'd0) begin
            pd_phase = i2cram_pkg::PH_STOP_FINAL;
          end else begin
            pd_phase = i2cram_pkg::PH_WR_DATA;
            pd_shift = in_word.wr_byte;
            pd_taken = 1'b1;
            pd_dec   = 1'b1;
          end
        end
        i2cram_pkg::PH_MID_STOP: pd_phase = i2cram_pkg::PH_START2;
        i2cram_pkg::PH_START2: begin
          pd_phase = i2cram_pkg::PH_WR_ADDRR;
          pd_shift = {addr, 1'b1};
        end
        i2cram_pkg::PH_WR_ADDRR: pd_phase = i2cram_pkg::PH_ACK_ADDRR;
        i2cram_pkg::PH_ACK_ADDRR, i2cram_pkg::PH_RD_ACK: begin
          pd_phase = (left_r == 8'd0) ? i2cram_pkg::PH_STOP_FINAL : i2cram_pkg::PH_RD_DATA;
        end
        i2cram_pkg::PH_WR_DATA:    pd_phase = i2cram_pkg::PH_ACK_DATA;
        i2cram_pkg::PH_STOP_FINAL: pd_done = 1'b1;
        default:                   pd_phase = i2cram_pkg::PH_IDLE;
      endcase
    end
  end

  // One tick of the bus sequencer.
  always_comb begin
    phase_nxt   = phase_r;
    sub_nxt     = sub_r;
    bit_nxt     = bit_r;
    rd_op_nxt   = rd_op_r;
    reg_nxt     = reg_r;
    left_nxt    = left_r;
    shift_nxt   = shift_r;
    timer_nxt   = timer_r;
    ack_cnt_nxt = ack_cnt_r;
    status_nxt  = status_r;
    apply_pd    = 1'b0;
    taken       = 1'b0;
    rv          = 1'b0;
    rb          = 8'd0;
    done        = 1'b0;

    if (phase_r == i2cram_pkg::PH_IDLE) begin
      if (in_word.func == i2cram_pkg::FUNC_READ || in_word.func == i2cram_pkg::FUNC_WRITE) begin
        rd_op_nxt  = in_word.func == i2cram_pkg::FUNC_READ;
        reg_nxt    = in_word.reg_index;
        left_nxt   = in_word.byte_count;
        status_nxt = i2cram_pkg::ST_OK;
        phase_nxt  = i2cram_pkg::PH_START1;
        sub_nxt    = 2'd0;
        bit_nxt    = 4'd0;
        timer_nxt  = '0;
        shift_nxt  = 8'd0;
      end
    end else if (is_ack(phase_r) && sub_r == 2'd1) begin
      if (!in_word.sda_in) begin
        sub_nxt   = 2'd2;
        timer_nxt = '0;
      end else begin
        ack_cnt_nxt = cnt_wrap;
        if (cnt_cmp >= lim_sat) begin
          status_nxt = fail_code(phase_r);
          sub_nxt    = 2'd2;
          timer_nxt  = '0;
        end
      end
    end else if (timer_inc < half_sat) begin
      timer_nxt = TIMER_BITS'(timer_inc);
    end else begin
      timer_nxt = '0;
      if (is_start(phase_r) || is_stop(phase_r) || phase_r == i2cram_pkg::PH_RD_ACK) begin
        if (sub_r < 2'd2) sub_nxt = sub_r + 2'd1;
        else apply_pd = 1'b1;
      end else if (is_write(phase_r)) begin
        if (bit_r == 4'd0) begin
          bit_nxt = 4'd1;
          sub_nxt = 2'd0;
        end else if (sub_r < 2'd2) begin
          sub_nxt = sub_r + 2'd1;
        end else begin
          shift_nxt = {shift_r[6:0], shift_r[7]};
          if (bit_r < 4'd8) begin
            bit_nxt = bit_r + 4'd1;
            sub_nxt = 2'd0;
          end else begin
            apply_pd = 1'b1;
          end
        end
      end else if (is_ack(phase_r)) begin
        if (sub_r == 2'd0) begin
          sub_nxt     = 2'd1;
          ack_cnt_nxt = '0;
        end else begin
          apply_pd = 1'b1;
        end
      end else if (phase_r == i2cram_pkg::PH_RD_DATA) begin
        if (bit_r == 4'd0) begin
          bit_nxt = 4'd1;
          sub_nxt = 2'd0;
        end else if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          shift_nxt = {shift_r[6:0], in_word.sda_in};
          if (bit_r < 4'd8) begin
            bit_nxt = bit_r + 4'd1;
            sub_nxt = 2'd0;
          end else begin
            rv = 1'b1;
            rb = {shift_r[6:0], in_word.sda_in};
            if (left_r != 8'd0) left_nxt = left_r - 8'd1;
            phase_nxt = i2cram_pkg::PH_RD_ACK;
            sub_nxt   = 2'd0;
            bit_nxt   = 4'd0;
          end
        end
      end else begin
        phase_nxt = i2cram_pkg::PH_IDLE;
        sub_nxt   = 2'd0;
        bit_nxt   = 4'd0;
        shift_nxt = 8'd0;
      end
    end

    if (apply_pd) begin
      phase_nxt = pd_phase;
      sub_nxt   = 2'd0;
      bit_nxt   = 4'd0;
      shift_nxt = pd_shift;
      taken     = pd_taken;
      done      = pd_done;
      if (pd_dec) left_nxt = left_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cram_pkg::PH_IDLE;
      sub_r     <= 2'd0;
      bit_r     <= 4'd0;
      rd_op_r   <= 1'b0;
      reg_r     <= 16'd0;
      left_r    <= 8'd0;
      shift_r   <= 8'd0;
      timer_r   <= '0;
      ack_cnt_r <= '0;
      status_r  <= i2cram_pkg::ST_OK;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      sub_r     <= sub_nxt;
      bit_r     <= bit_nxt;
      rd_op_r   <= rd_op_nxt;
      reg_r     <= reg_nxt;
      left_r    <= left_nxt;
      shift_r   <= shift_nxt;
      timer_r   <= timer_nxt;
      ack_cnt_r <= ack_cnt_nxt;
      status_r  <= status_nxt;
    end
  end

  always_comb begin
    res            = '0;
    res.scl        = scl;
    res.sda_out    = sda;
    res.sda_oe     = oe;
    res.busy_res   = phase_r != i2cram_pkg::PH_IDLE;
    res.byte_taken = taken;
    res.rd_valid   = rv;
    res.rd_byte    = rb;
    res.done_res   = done;
    res.status     = done ? status_r : i2cram_pkg::ST_OK;
  end

endmodule

// ===== rtl/core/i2c_register_access_master.sv =====
// I2C master for register reads and writes at 16-bit register addresses, one bus tick per word.
// Input channel (in_valid/in_ready/in_word): each word is one tick carrying
// the sampled SDA level, the next write byte and, while idle, a command
// (func read or write, register address, byte count).
// Result channel (out_valid/out_ready/out_word): exactly one word per input
// word, in order: SCL/SDA drive levels, busy, byte taken, received byte,
// done and status.
// Config port (cfg_wr_en/cfg_index/cfg_data): device address, half period
// in ticks and acknowledge timeout; write only while no transfer is active.
// Each result word is registered in the output register, or in the second buffer entry while the output is stalled.
// Throughput: one word per cycle while in_ready is high, since the sequencer step
// between the input and the output register is combinational.
// A two-entry output buffer keeps in_ready high while the output is stalled;
// in_ready falls only once both entries hold words, and no word is lost.
// Reset (synchronous, rst_n low) returns the sequencer to idle, empties the
// output buffer and restores the register defaults (93, 50, 2000).
module i2c_register_access_master #(
  parameter int TIMER_BITS = i2cram_pkg::TIMER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  i2cram_pkg::in_word_t                in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output i2cram_pkg::out_word_t               out_word,
  input  logic                                cfg_wr_en,
  input  logic [i2cram_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2cram_pkg::CFG_DATA_W-1:0]   cfg_data
);

  `include "i2c_register_access_master_macros.svh"

  i2cram_pkg::cfg_t      cfg_r;
  i2cram_pkg::out_word_t res;
  i2cram_pkg::out_word_t out_word_r, out_word_nxt;
  i2cram_pkg::out_word_t skid_word_r, skid_word_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  skid_vld_r, skid_vld_nxt;
  logic                  in_fire, out_take;

  assign in_ready  = !skid_vld_r;
  assign in_fire   = in_valid && in_ready;
  assign out_take  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr    <= i2cram_pkg::DEV_ADDR_RST;
      cfg_r.half_period <= i2cram_pkg::HALF_PERIOD_RST;
      cfg_r.ack_limit   <= i2cram_pkg::ACK_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        i2cram_pkg::CFG_DEV_ADDR:    cfg_r.dev_addr    <= cfg_data[6:0];
        i2cram_pkg::CFG_HALF_PERIOD: cfg_r.half_period <= cfg_data[15:0];
        i2cram_pkg::CFG_ACK_LIMIT:   cfg_r.ack_limit   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  i2cram_engine #(
    .TIMER_BITS(TIMER_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .in_word (in_word),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    skid_vld_nxt  = skid_vld_r;
    skid_word_nxt = skid_word_r;
    if (out_take) begin
      if (skid_vld_r) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = skid_word_r;
        skid_vld_nxt  = 1'b0;
      end else if (in_fire) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      skid_vld_nxt  = 1'b1;
      skid_word_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_vld_r  <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  `I2CRAM_ASSERT_NOW(a_skid_behind_out, skid_vld_r, out_valid_r, "skid word without output word")
  `I2CRAM_ASSERT_NOW(a_idle_bus_released, out_valid_r && !out_word_r.busy_res,
    out_word_r.scl && out_word_r.sda_out && !out_word_r.sda_oe, "idle word drives the bus")
  `I2CRAM_ASSERT_NOW(a_status_with_done, out_valid_r && !out_word_r.done_res,
    out_word_r.status == i2cram_pkg::ST_OK, "status reported without done")
  `I2CRAM_ASSERT_NEXT(a_full_holds_ready, skid_vld_r && !out_ready,
    !in_ready, "input taken while buffer full")

endmodule

// ===== tb/sv/tb_i2c_register_access_master.sv =====
module tb_i2c_register_access_master;
  import i2cram_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  class i2c_master_shadow;
    phase_t      phase;
    int unsigned sub_step;
    logic [3:0]  bit_idx;
    logic        is_read;
    logic [15:0] reg_latch;
    logic [7:0]  left;
    logic [7:0]  shreg;
    logic [15:0] hp_timer;
    logic [15:0] ack_cnt;
    logic [1:0]  st_latch;
    logic [6:0]  dev_addr;
    logic [15:0] half_period;
    logic [15:0] ack_limit;
    logic        taken_now;
    logic        done_now;
    out_word_t   due_levels[$];
    int          errors, ticks, finished, bytes_rx, bytes_tx;
    int          by_status[4];

    function new();
      dev_addr = DEV_ADDR_RST;
      half_period = HALF_PERIOD_RST;
      ack_limit = ACK_LIMIT_RST;
      is_read = 1'b0;
      reg_latch = '0;
      left = '0;
      st_latch = ST_OK;
      ack_cnt = '0;
      enter(PH_IDLE, 8'h00);
    endfunction

    function bit is_start(phase_t p);
      return p == PH_START1 || p == PH_START2;
    endfunction

    function bit is_stop(phase_t p);
      return p == PH_MID_STOP || p == PH_STOP_FINAL;
    endfunction

    function bit is_wr(phase_t p);
      return p == PH_WR_ADDRW || p == PH_WR_REGHI || p == PH_WR_REGLO ||
             p == PH_WR_ADDRR || p == PH_WR_DATA;
    endfunction

    function bit is_ack(phase_t p);
      return p == PH_ACK_ADDRW || p == PH_ACK_REGHI || p == PH_ACK_REGLO ||
             p == PH_ACK_ADDRR || p == PH_ACK_DATA;
    endfunction

    function void enter(phase_t p, logic [7:0] sh);
      phase = p;
      sub_step = 0;
      bit_idx = '0;
      hp_timer = '0;
      shreg = sh;
    endfunction

    function void take_byte(logic [7:0] wr);
      left = left - 8'd1;
      taken_now = 1'b1;
      enter(PH_WR_DATA, wr);
    endfunction

    function void phase_done(logic [7:0] wr);
      if (is_ack(phase) && st_latch != ST_OK) begin
        enter(PH_STOP_FINAL, 8'h00);
        return;
      end
      case (phase)
        PH_START1:    enter(PH_WR_ADDRW, {dev_addr, 1'b0});
        PH_WR_ADDRW:  enter(PH_ACK_ADDRW, 8'h00);
        PH_ACK_ADDRW: enter(PH_WR_REGHI, reg_latch[15:8]);
        PH_WR_REGHI:  enter(PH_ACK_REGHI, 8'h00);
        PH_ACK_REGHI: enter(PH_WR_REGLO, reg_latch[7:0]);
        PH_WR_REGLO:  enter(PH_ACK_REGLO, 8'h00);
        PH_ACK_REGLO: begin
          if (is_read) enter(PH_MID_STOP, 8'h00);
          else if (left == 0) enter(PH_STOP_FINAL, 8'h00);
          else take_byte(wr);
        end
        PH_MID_STOP:  enter(PH_START2, 8'h00);
        PH_START2:    enter(PH_WR_ADDRR, {dev_addr, 1'b1});
        PH_WR_ADDRR:  enter(PH_ACK_ADDRR, 8'h00);
        PH_ACK_ADDRR, PH_RD_ACK: begin
          if (left == 0) enter(PH_STOP_FINAL, 8'h00);
          else enter(PH_RD_DATA, 8'h00);
        end
        PH_WR_DATA:   enter(PH_ACK_DATA, 8'h00);
        PH_ACK_DATA: begin
          if (left == 0) enter(PH_STOP_FINAL, 8'h00);
          else take_byte(wr);
        end
        PH_STOP_FINAL: begin
          done_now = 1'b1;
          enter(PH_IDLE, 8'h00);
        end
        default: enter(PH_IDLE, 8'h00);
      endcase
    endfunction

    // {scl, sda_out, sda_oe} held during the current tick
    function logic [2:0] bus_levels();
      if (is_start(phase))
        return {sub_step != 0, sub_step != 2, sub_step != 0};
      if (is_stop(phase))
        return {sub_step != 0, sub_step == 2, 1'b1};
      if (is_wr(phase)) begin
        if (bit_idx == 0) return 3'b001;
        if (sub_step == 0) return {1'b0, (bit_idx == 1) ? 1'b0 : shreg[0], 1'b1};
        return {sub_step == 2, shreg[7], 1'b1};
      end
      if (is_ack(phase)) return {sub_step == 2, 2'b10};
      if (phase == PH_RD_DATA) return {bit_idx != 0 && sub_step == 1, 2'b10};
      if (phase == PH_RD_ACK)
        return {sub_step == 2, (sub_step == 0) ? 1'b1 : (left == 0), sub_step != 0};
      return 3'b110;
    endfunction

    function out_word_t advance(in_word_t w);
      out_word_t   r;
      int unsigned h;
      int unsigned lim;
      r = '0;
      taken_now = 1'b0;
      done_now = 1'b0;
      r.busy_res = (phase != PH_IDLE);
      h = (half_period == 0) ? 1 : half_period;
      lim = ack_limit;
      {r.scl, r.sda_out, r.sda_oe} = bus_levels();
      if (phase == PH_IDLE) begin
        if (w.func == FUNC_READ || w.func == FUNC_WRITE) begin
          is_read = (w.func == FUNC_READ);
          reg_latch = w.reg_index;
          left = w.byte_count;
          st_latch = ST_OK;
          enter(PH_START1, 8'h00);
        end
      end else if (is_ack(phase) && sub_step == 1) begin
        if (!w.sda_in) begin
          sub_step = 2;
          hp_timer = '0;
        end else begin
          ack_cnt = ack_cnt + 16'd1;
          if (ack_cnt >= lim) begin
            if (phase == PH_ACK_ADDRW) st_latch = ST_ADDR_NACK;
            else if (phase == PH_ACK_REGHI || phase == PH_ACK_REGLO) st_latch = ST_REG_NACK;
            else st_latch = ST_DATA_NACK;
            sub_step = 2;
            hp_timer = '0;
          end
        end
      end else if (hp_timer + 1 < h) begin
        hp_timer = hp_timer + 16'd1;
      end else begin
        hp_timer = '0;
        if (is_start(phase) || is_stop(phase) || phase == PH_RD_ACK) begin
          if (sub_step < 2) sub_step++;
          else phase_done(w.wr_byte);
        end else if (is_wr(phase)) begin
          if (bit_idx == 0) begin
            bit_idx = 4'd1;
            sub_step = 0;
          end else if (sub_step < 2) begin
            sub_step++;
          end else begin
            shreg = {shreg[6:0], shreg[7]};
            if (bit_idx < 8) begin
              bit_idx++;
              sub_step = 0;
            end else begin
              phase_done(w.wr_byte);
            end
          end
        end else if (is_ack(phase)) begin
          if (sub_step == 0) begin
            sub_step = 1;
            ack_cnt = '0;
          end else begin
            phase_done(w.wr_byte);
          end
        end else if (phase == PH_RD_DATA) begin
          if (bit_idx == 0) begin
            bit_idx = 4'd1;
            sub_step = 0;
          end else if (sub_step == 0) begin
            sub_step = 1;
          end else begin
            shreg = {shreg[6:0], w.sda_in};
            if (bit_idx < 8) begin
              bit_idx++;
              sub_step = 0;
            end else begin
              r.rd_valid = 1'b1;
              r.rd_byte = shreg;
              if (left > 0) left--;
              enter(PH_RD_ACK, shreg);
            end
          end
        end else begin
          enter(PH_IDLE, 8'h00);
        end
      end
      r.byte_taken = taken_now;
      r.done_res = done_now;
      r.status = done_now ? st_latch : ST_OK;
      return r;
    endfunction

    function void note_tick(in_word_t w);
      due_levels.push_back(advance(w));
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_tick(out_word_t got);
      out_word_t want;
      if (due_levels.size() == 0) begin
        $error("result word %h with nothing expected", got);
        errors++;
        return;
      end
      want = due_levels.pop_front();
      ticks++;
      cmp("scl", want.scl, got.scl);
      cmp("sda_out", want.sda_out, got.sda_out);
      cmp("sda_oe", want.sda_oe, got.sda_oe);
      cmp("busy_res", want.busy_res, got.busy_res);
      cmp("byte_taken", want.byte_taken, got.byte_taken);
      cmp("rd_valid", want.rd_valid, got.rd_valid);
      cmp("rd_byte", want.rd_byte, got.rd_byte);
      cmp("done_res", want.done_res, got.done_res);
      cmp("status", want.status, got.status);
      if (want.done_res) begin
        finished++;
        by_status[want.status]++;
      end
      if (want.rd_valid) bytes_rx++;
      if (want.byte_taken) bytes_tx++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  i2c_master_shadow sb;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  int unsigned      nack_pct = 0;
  int unsigned      words_sent = 0;
  int unsigned      cycles = 0;
  phase_t           nack_phase = PH_IDLE;
  logic             ack_fails = 1'b0;

  i2c_register_access_master dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_tick(out_word);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // target device: acks after a short random delay unless this ack is to fail
  function automatic logic slave_sda();
    if (sb.is_ack(sb.phase)) begin
      if (sb.sub_step == 0)
        ack_fails = (sb.phase == nack_phase) || ($urandom_range(0, 99) < nack_pct);
      else if (sb.sub_step == 1)
        return ack_fails ? 1'b1 : ($urandom_range(0, 3) == 0);
    end
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_tick(logic [1:0] func, logic [15:0] ra, logic [7:0] cnt);
    in_word_t w;
    w.func = func;
    w.reg_index = ra;
    w.byte_count = cnt;
    w.wr_byte = 8'($urandom_range(0, 255));
    w.sda_in = slave_sda();
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(w);
    words_sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic run_transfer(logic [1:0] func, logic [15:0] ra, logic [7:0] cnt);
    send_tick(func, ra, cnt);
    while (sb.phase != PH_IDLE)
      send_tick(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.due_levels.size() != 0) @(posedge clk);
  endtask

  task automatic configure(logic [6:0] dev, logic [15:0] half, logic [15:0] lim);
    logic [CFG_IDX_W-1:0]  idx[3];
    logic [CFG_DATA_W-1:0] vals[3];
    idx[0] = CFG_DEV_ADDR;
    idx[1] = CFG_HALF_PERIOD;
    idx[2] = CFG_ACK_LIMIT;
    vals[0] = {9'd0, dev};
    vals[1] = half;
    vals[2] = lim;
    wait_drained();
    for (int i = 0; i < 3; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    sb.dev_addr = dev;
    sb.half_period = half;
    sb.ack_limit = lim;
  endtask

  initial begin
    int unsigned target;
    sb = new();
    tx_idle_pct = 19;
    rx_idle_pct = 54;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks out of reset
    send_tick(FUNC_TICK, 16'h1234, 8'd0);
    send_tick(2'd3, 16'h1234, 8'd0);

    // zero half period and zero ack limit, unused func code while idle
    configure(7'd0, 16'd0, 16'd0);
    send_tick(2'd3, 16'hFFFF, 8'hFF);
    send_tick(FUNC_TICK, 16'hFFFF, 8'hFF);
    run_transfer(FUNC_READ, 16'hFFFF, 8'd1);

    configure(7'd127, 16'd1, 16'd8);
    run_transfer(FUNC_READ, 16'h00FF, 8'd0);
    nack_phase = PH_ACK_ADDRW;
    run_transfer(FUNC_WRITE, 16'h0001, 8'd1);
    nack_phase = PH_ACK_REGHI;
    run_transfer(FUNC_READ, 16'h8000, 8'd1);
    nack_phase = PH_ACK_REGLO;
    run_transfer(FUNC_WRITE, 16'h7FFF, 8'd1);
    nack_phase = PH_ACK_DATA;
    run_transfer(FUNC_WRITE, 16'h8001, 8'd255);
    nack_phase = PH_ACK_ADDRR;
    run_transfer(FUNC_READ, 16'h7FFE, 8'd255);
    nack_phase = PH_IDLE;

    configure(7'h2A, 16'd1, 16'hFFFF);
    run_transfer(FUNC_READ, 16'hC3C3, 8'd2);
    run_transfer(FUNC_WRITE, 16'h5AA5, 8'd1);

    // slowest bus setting: idle ticks only
    configure(7'd93, 16'hFFFF, 16'd3);
    for (int i = 0; i < 4; i++)
      send_tick(($urandom_range(0, 1) != 0) ? 2'd3 : FUNC_TICK, 16'($urandom), 8'($urandom));

    nack_pct = 6;
    for (int blk = 0; blk < 3; blk++) begin
      case (blk)
        0: begin tx_idle_pct = 19; rx_idle_pct = 54; end
        1: begin tx_idle_pct = 54; rx_idle_pct = 19; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      target = words_sent + 100;
      while (words_sent < target) begin
        configure(7'($urandom_range(0, 127)),
                  16'(($urandom_range(0, 4) == 0) ? $urandom_range(2, 3)
                                                  : $urandom_range(0, 1)),
                  16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(4, 40)));
        if ($urandom_range(0, 7) == 0)
          send_tick(($urandom_range(0, 1) != 0) ? 2'd3 : FUNC_TICK,
                    16'($urandom), 8'($urandom));
        else
          run_transfer(2'($urandom_range(1, 2)), 16'($urandom),
                       8'(($urandom_range(0, 15) == 0) ? $urandom_range(5, 12)
                                                       : $urandom_range(0, 3)));
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("checked %0d bus ticks over %0d transfers: %0d clean, %0d address nack,",
             sb.ticks, sb.finished, sb.by_status[ST_OK], sb.by_status[ST_ADDR_NACK]);
    $display("%0d register nack, %0d read/data nack; %0d bytes read, %0d bytes written",
             sb.by_status[ST_REG_NACK], sb.by_status[ST_DATA_NACK], sb.bytes_rx,
             sb.bytes_tx);
    if (sb.errors == 0 && sb.due_levels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/i2cram_pkg.sv
rtl/core/i2cram_engine.sv
rtl/core/i2c_register_access_master.sv
tb/sv/tb_i2c_register_access_master.sv
